### hdl/lvn_pkg.sv
`default_nettype none

package lvn_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = 13;
    localparam int FRAC_W     = 17;
    localparam int NOISE_W    = 22;

    localparam logic [63:0] LCG_MUL = 64'h0000_FFD3_02A2_F2D1;
    localparam logic [63:0] LCG_INC = 64'd4093;

    typedef enum logic [1:0] {
        OP_RESEED  = 2'd0,
        OP_SAMPLE2 = 2'd1,
        OP_SAMPLE3 = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [3:0]         sel;
        logic [IDX_W-1:0]   ix;
        logic [IDX_W-1:0]   iy;
        logic [IDX_W-1:0]   iz;
        logic [IDX_W-1:0]   mx;
        logic [IDX_W-1:0]   my;
        logic [IDX_W-1:0]   mz;
        logic [FRAC_W-1:0]  fx;
        logic [FRAC_W-1:0]  fy;
        logic [FRAC_W-1:0]  fz;
    } job_t;

endpackage

`default_nettype wire

### hdl/lvn_front.sv
`default_nettype none

module lvn_front #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [1:0]         operation,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic signed [31:0] coord_z,
    input  wire logic [15:0]        mask_x,
    input  wire logic [15:0]        mask_y,
    input  wire logic [15:0]        mask_z,
    input  wire logic [3:0]         table_select,
    input  wire logic               full,
    output logic                    push,
    output lvn_pkg::job_t           job,
    output logic                    pending
);

    localparam int F     = COORD_FRAC_BITS;
    localparam int S_VAL = 1 << F;
    localparam int IW    = lvn_pkg::IDX_W;
    localparam int FW    = lvn_pkg::FRAC_W;

    logic                 valid_reg, valid_next;
    lvn_pkg::job_t        job_reg, job_next;
    logic                 accept;
    logic signed [31:0]   crd   [3];
    logic signed [31:0]   quo   [3];
    logic                 adj   [3];
    logic [IW-1:0]        ixl   [3];
    logic [FW-1:0]        frac  [3];

    assign accept  = start & ~busy;
    assign push    = valid_reg & ~full;
    assign job     = job_reg;
    assign pending = valid_reg;

    assign crd[0] = coord_x;
    assign crd[1] = coord_y;
    assign crd[2] = coord_z;

    // Integer parts truncate toward zero, so a negative value with a fraction moves up one.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quo[i]  = crd[i] >>> F;
            adj[i]  = crd[i][31] & (|crd[i][F-1:0]);
            ixl[i]  = quo[i][IW-1:0] + {{(IW-1){1'b0}}, adj[i]};
            frac[i] = {{(FW-F){1'b0}}, crd[i][F-1:0]} - (adj[i] ? FW'(S_VAL) : '0);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        job_next   = job_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next  = 1'b1;
            job_next.op  = lvn_pkg::op_t'(operation);
            job_next.sel = table_select;
            job_next.ix  = ixl[0];
            job_next.iy  = ixl[1];
            job_next.iz  = ixl[2];
            job_next.mx  = mask_x[IW-1:0];
            job_next.my  = mask_y[IW-1:0];
            job_next.mz  = mask_z[IW-1:0];
            job_next.fx  = frac[0];
            job_next.fy  = frac[1];
            job_next.fz  = frac[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

`default_nettype wire

### hdl/lvn_queue.sv
`default_nettype none

module lvn_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lvn_pkg::job_t  push_job,
    output logic                full,
    input  wire logic           pop,
    output lvn_pkg::job_t       head,
    output logic                empty
);

    localparam int DEPTH = 2;

    lvn_pkg::job_t  entry_reg [DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### hdl/lvn_back.sv
`default_nettype none

module lvn_back #(
    parameter int TABLE_COUNT     = 16,
    parameter int WARMUP_STEPS    = 4096,
    parameter int COORD_FRAC_BITS = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 job_valid,
    input  wire lvn_pkg::job_t                        job,
    input  wire logic [63:0]                          seed,
    output logic                                      pop,
    output logic                                      busy,
    output logic                                      result_valid,
    output logic signed [lvn_pkg::NOISE_W-1:0]        noise_value,
    output logic                                      reseed_done
);

    localparam int F      = COORD_FRAC_BITS;
    localparam int S_VAL  = 1 << F;
    localparam int IW     = lvn_pkg::IDX_W;
    localparam int NW     = lvn_pkg::NOISE_W;
    localparam int DEPTH  = TABLE_COUNT * lvn_pkg::TABLE_SIZE;
    localparam int MAW    = $clog2(DEPTH);
    localparam int TW     = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int TOTAL  = WARMUP_STEPS + DEPTH;
    localparam int CW     = $clog2(TOTAL);
    localparam int WW     = F + 2;
    localparam int W1     = 8 + WW;
    localparam int W2     = W1 + WW;
    localparam int W3     = W2 + WW;
    localparam int ACCW   = W3 + 3;
    localparam int EXTW   = ACCW + 16;
    localparam int FB2    = 7 + 2 * F;
    localparam int FB3    = 7 + 3 * F;
    localparam int SHR2   = (FB2 >= 16) ? FB2 - 16 : 0;
    localparam int SHL2   = (FB2 >= 16) ? 0 : 16 - FB2;
    localparam int SHR3   = (FB3 >= 16) ? FB3 - 16 : 0;
    localparam int SHL3   = (FB3 >= 16) ? 0 : 16 - FB3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LCG,
        ST_READ,
        ST_DRAIN
    } state_t;

    state_t                 state_reg, state_next;
    lvn_pkg::job_t          job_reg, job_next;
    logic [63:0]            gen_reg, gen_next;
    logic [63:0]            lacc_reg, lacc_next;
    logic [63:0]            prod_reg, prod_next;
    logic [1:0]             phase_reg, phase_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [MAW-1:0]         waddr_reg, waddr_next;
    logic [2:0]             k_reg, k_next;
    logic                   rv_reg, rv_next;
    logic signed [NW-1:0]   noise_reg, noise_next;
    logic                   done_reg, done_next;

    logic [7:0]             mem [DEPTH];
    logic [7:0]             rd_data_reg;
    logic                   mem_we, rd_en, sum_clear;

    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2:0]             k1_reg, k2_reg, k3_reg;
    logic signed [W1-1:0]   m1_reg;
    logic signed [W2-1:0]   m2_reg;
    logic signed [W3-1:0]   m3_reg;
    logic signed [ACCW-1:0] sum_reg;

    logic [31:0]            mul_a, mul_b;
    logic [63:0]            mul_p, gen_new;
    logic                   is3d;
    logic [2:0]             last_k;
    logic [TW-1:0]          sel_lut [16];
    logic [IW-1:0]          cx, cy, cz, a13, b13, c13, p13, q13;
    logic [7:0]             a8, b8, idx2, idx;
    logic [MAW-1:0]         rd_addr;
    logic signed [7:0]      v_s;
    logic signed [F:0]      fx_s, fy_s, fz_s;
    logic signed [WW-1:0]   one_w, w_x, w_y, w_z;
    logic signed [EXTW-1:0] sum_ext, q16;

    for (genvar i = 0; i < 16; i++)
    begin : g_sel
        assign sel_lut[i] = TW'(i % TABLE_COUNT);
    end

    assign is3d   = (job_reg.op == lvn_pkg::OP_SAMPLE3);
    assign last_k = is3d ? 3'd7 : 3'd3;
    assign busy   = (state_reg != ST_IDLE);

    assign result_valid = rv_reg;
    assign noise_value  = noise_reg;
    assign reseed_done  = done_reg;

    // The 64-bit generator step is split into three 32-bit partial products.
    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                mul_a = gen_reg[31:0];
                mul_b = lvn_pkg::LCG_MUL[31:0];
            end
            2'd1:
            begin
                mul_a = gen_reg[31:0];
                mul_b = lvn_pkg::LCG_MUL[63:32];
            end
            default:
            begin
                mul_a = gen_reg[63:32];
                mul_b = lvn_pkg::LCG_MUL[31:0];
            end
        endcase
        mul_p   = {32'b0, mul_a} * {32'b0, mul_b};
        gen_new = lacc_reg + {prod_reg[31:0], 32'b0} + lvn_pkg::LCG_INC;
    end

    always_comb
    begin
        cx   = (job_reg.ix + {{(IW-1){1'b0}}, k_reg[0]}) & job_reg.mx;
        cy   = (job_reg.iy + {{(IW-1){1'b0}}, k_reg[1]}) & job_reg.my;
        cz   = (job_reg.iz + {{(IW-1){1'b0}}, k_reg[2]}) & job_reg.mz;
        a8   = {cx[6:0], 1'b0} - cy[7:0];
        b8   = {cy[6:0], 1'b0} - cx[7:0];
        idx2 = b8 * 8'd15 + a8;
        a13  = {cx[IW-2:0], 1'b0} - cy;
        b13  = {cy[IW-2:0], 1'b0} - cx;
        c13  = {cz[IW-2:0], 1'b0} - {b13[IW-2:0], 1'b0} + a13;
        p13  = c13 * 13'd7 + b13 * 13'd3 + a13;
        q13  = p13 * 13'd31;
        idx  = is3d ? q13[IW-1:5] : idx2;
        rd_addr = MAW'({sel_lut[job_reg.sel], idx});
    end

    always_comb
    begin
        fx_s  = job_reg.fx[F:0];
        fy_s  = job_reg.fy[F:0];
        fz_s  = job_reg.fz[F:0];
        one_w = WW'(S_VAL);
        v_s   = {~rd_data_reg[7], rd_data_reg[6:0]};
        w_x   = k1_reg[0] ? WW'(fx_s) : one_w - WW'(fx_s);
        w_y   = k2_reg[1] ? WW'(fy_s) : one_w - WW'(fy_s);
        w_z   = k3_reg[2] ? WW'(fz_s) : one_w - WW'(fz_s);
        sum_ext = EXTW'(sum_reg);
        if (is3d)
        begin
            q16 = (sum_ext >>> SHR3) <<< SHL3;
        end
        else
        begin
            q16 = (sum_ext >>> SHR2) <<< SHL2;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        gen_next   = gen_reg;
        lacc_next  = lacc_reg;
        prod_next  = prod_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        waddr_next = waddr_reg;
        k_next     = k_reg;
        rv_next    = 1'b0;
        noise_next = noise_reg;
        done_next  = done_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        sum_clear  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    pop      = 1'b1;
                    job_next = job;
                    unique case (job.op) inside
                        lvn_pkg::OP_RESEED:
                        begin
                            gen_next   = seed;
                            phase_next = 2'd0;
                            cnt_next   = '0;
                            waddr_next = '0;
                            state_next = ST_LCG;
                        end
                        lvn_pkg::OP_SAMPLE2, lvn_pkg::OP_SAMPLE3:
                        begin
                            k_next     = 3'd0;
                            sum_clear  = 1'b1;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            rv_next    = 1'b1;
                            noise_next = '0;
                            done_next  = 1'b0;
                        end
                    endcase
                end
            end
            ST_LCG:
            begin
                prod_next  = mul_p;
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    2'd1:
                    begin
                        lacc_next = prod_reg;
                    end
                    2'd2:
                    begin
                        lacc_next = lacc_reg + {prod_reg[31:0], 32'b0};
                    end
                    2'd3:
                    begin
                        gen_next = gen_new;
                        if (cnt_reg >= CW'(WARMUP_STEPS))
                        begin
                            mem_we     = 1'b1;
                            waddr_next = waddr_reg + MAW'(1);
                        end
                        if (cnt_reg == CW'(TOTAL - 1))
                        begin
                            rv_next    = 1'b1;
                            noise_next = '0;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_READ:
            begin
                rd_en  = 1'b1;
                k_next = k_reg + 3'd1;
                if (k_reg == last_k)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!(v1_reg | v2_reg | v3_reg | v4_reg))
                begin
                    rv_next    = 1'b1;
                    noise_next = q16[NW-1:0];
                    done_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            gen_reg   <= '0;
            phase_reg <= 2'd0;
            cnt_reg   <= '0;
            waddr_reg <= '0;
            k_reg     <= 3'd0;
            rv_reg    <= 1'b0;
            done_reg  <= 1'b0;
            noise_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            waddr_reg <= waddr_next;
            k_reg     <= k_next;
            rv_reg    <= rv_next;
            done_reg  <= done_next;
            noise_reg <= noise_next;
            v1_reg    <= rd_en;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        lacc_reg <= lacc_next;
        prod_reg <= prod_next;
        k1_reg   <= k_reg;
        k2_reg   <= k1_reg;
        k3_reg   <= k2_reg;
        m1_reg   <= v_s * w_x;
        m2_reg   <= m1_reg * w_y;
        if (is3d)
        begin
            m3_reg <= m2_reg * w_z;
        end
        else
        begin
            m3_reg <= W3'(m2_reg);
        end
        if (sum_clear)
        begin
            sum_reg <= '0;
        end
        else if (v4_reg)
        begin
            sum_reg <= sum_reg + ACCW'(m3_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr_reg] <= gen_new[55:48];
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/lattice_value_noise_sampler_core.sv
// One request is in flight at a time; busy stays high until its result is issued.
// The table memory gives one corner a cycle, and each generator step runs through its
// multiplier phases in turn. Reset clears control state, the seed register and the
// generator; tables hold no defined data until the first reseed. The receiver cannot
// stall the result strobe.
`default_nettype none

module lattice_value_noise_sampler_core #(
    parameter int TABLE_COUNT     = 16,
    parameter int WARMUP_STEPS    = 4096,
    parameter int COORD_FRAC_BITS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       operation,
    input  wire logic signed [31:0]               coord_x,
    input  wire logic signed [31:0]               coord_y,
    input  wire logic signed [31:0]               coord_z,
    input  wire logic [15:0]                      mask_x,
    input  wire logic [15:0]                      mask_y,
    input  wire logic [15:0]                      mask_z,
    input  wire logic [3:0]                       table_select,
    input  wire logic                             seed_we,
    input  wire logic [63:0]                      seed_data,
    output logic                                  result_valid,
    output logic signed [lvn_pkg::NOISE_W-1:0]    noise_value,
    output logic                                  reseed_done
);

    logic [63:0]    seed_reg;
    logic           front_push, front_pending;
    lvn_pkg::job_t  front_job, queue_head;
    logic           queue_full, queue_empty;
    logic           back_pop, back_busy;

    assign busy = front_pending | ~queue_empty | back_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_we)
        begin
            seed_reg <= seed_data;
        end
    end

    lvn_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .mask_x       (mask_x),
        .mask_y       (mask_y),
        .mask_z       (mask_z),
        .table_select (table_select),
        .full         (queue_full),
        .push         (front_push),
        .job          (front_job),
        .pending      (front_pending)
    );

    lvn_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_job (front_job),
        .full     (queue_full),
        .pop      (back_pop),
        .head     (queue_head),
        .empty    (queue_empty)
    );

    lvn_back #(
        .TABLE_COUNT     (TABLE_COUNT),
        .WARMUP_STEPS    (WARMUP_STEPS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (~queue_empty),
        .job          (queue_head),
        .seed         (seed_reg),
        .pop          (back_pop),
        .busy         (back_busy),
        .result_valid (result_valid),
        .noise_value  (noise_value),
        .reseed_done  (reseed_done)
    );

endmodule

`default_nettype wire
